// File: rtl/core/lzss_stream_decompressor_assert.svh
// Assertion macros shared by the decompressor modules.
`ifndef LZSS_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LZSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lzss_pkg.sv
// Types, constants and command/status structs of the LZSS decompressor.
package lzss_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int ADDR_W      = $clog2(WINDOW_SIZE);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int LEN_W       = 5;

    localparam logic [ADDR_W-1:0] START_PTR = ADDR_W'(WINDOW_SIZE - 18);
    localparam logic [7:0]        FILL_BYTE = 8'h20;
    localparam logic [LEN_W-1:0]  MIN_MATCH = LEN_W'(3);

    // Header byte positions of the length field.
    localparam logic [1:0] HDR_B0 = 2'd0;
    localparam logic [1:0] HDR_B1 = 2'd1;
    localparam logic [1:0] HDR_B2 = 2'd2;
    localparam logic [1:0] HDR_B3 = 2'd3;

    typedef enum logic [2:0] {
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_CMD,
        ST_OFFHI,
        ST_LIT,
        ST_COPY
    } t_state;

    typedef struct packed {
        logic       in_ready;
        logic       hdr_ld;
        logic [1:0] hdr_idx;
        logic       flag_ld;
        logic       flag_shift;
        logic       lit_ld;
        logic       off_ld;
        logic       copy_start;
        logic       emit_lit;
        logic       emit_copy;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic hdr_zero;
        logic flag_empty;
        logic flag_bit;
        logic emit_last;
        logic copy_last;
    } t_stat;

endpackage

// File: rtl/core/lzss_in_if.sv
// Compressed byte channel.
interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink (input valid, input packed_byte, output ready);
endinterface

// File: rtl/core/lzss_out_if.sv
// Decompressed byte channel.
interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output run_last, output stream_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input stream_end,
                  output ready);
endinterface

// File: rtl/core/lzss_stream_decompressor.sv
// Top level of the LZSS stream decompressor with a 4096-byte history window.
//
//   channel   dir   beat payload
//   i_in      in    packed_byte[7:0]
//   o_out     out   out_byte[7:0], run_last, stream_end
//
// Header, flag and offset-low bytes are each taken in one parsing state; a literal
// byte is emitted from ST_LIT. A back-reference of 3 to 18 bytes is emitted through
// the single read port of the window memory, one byte per cycle unless stalled.
// Reset (synchronous, active low) needs no clearing pass: a fill count marks which
// window entries were written since stream start, and the rest read as 0x20.
// A stalled output holds the beat in the output register and freezes the copy.
module lzss_stream_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzss_in_if.sink     i_in,
    lzss_out_if.source  o_out
);

    lzss_pkg::t_cmd  cmd;
    lzss_pkg::t_stat stat;

    lzss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lzss_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_valid   (i_in.valid),
        .i_in_byte    (i_in.packed_byte),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_byte   (o_out.out_byte),
        .o_run_last   (o_out.run_last),
        .o_stream_end (o_out.stream_end)
    );

    assign i_in.ready = cmd.in_ready;

endmodule

// File: rtl/core/lzss_ctrl.sv
// Parsing state machine of the LZSS decompressor.
`include "lzss_stream_decompressor_assert.svh"

module lzss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lzss_pkg::t_stat i_stat,
    output lzss_pkg::t_cmd  o_cmd
);

    lzss_pkg::t_state r_state;
    lzss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzss_pkg::ST_HDR0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lzss_pkg::ST_HDR0: begin
                if (i_stat.in_valid) n_state = lzss_pkg::ST_HDR1;
            end
            lzss_pkg::ST_HDR1: begin
                if (i_stat.in_valid) n_state = lzss_pkg::ST_HDR2;
            end
            lzss_pkg::ST_HDR2: begin
                if (i_stat.in_valid) n_state = lzss_pkg::ST_HDR3;
            end
            lzss_pkg::ST_HDR3: begin
                if (i_stat.in_valid) begin
                    n_state = i_stat.hdr_zero ? lzss_pkg::ST_HDR0 : lzss_pkg::ST_CMD;
                end
            end
            lzss_pkg::ST_CMD: begin
                if (i_stat.in_valid && !i_stat.flag_empty) begin
                    n_state = i_stat.flag_bit ? lzss_pkg::ST_LIT : lzss_pkg::ST_OFFHI;
                end
            end
            lzss_pkg::ST_OFFHI: begin
                if (i_stat.in_valid) n_state = lzss_pkg::ST_COPY;
            end
            lzss_pkg::ST_LIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_last ? lzss_pkg::ST_HDR0 : lzss_pkg::ST_CMD;
                end
            end
            lzss_pkg::ST_COPY: begin
                if (i_stat.out_free) begin
                    if (i_stat.emit_last) begin
                        n_state = lzss_pkg::ST_HDR0;
                    end else if (i_stat.copy_last) begin
                        n_state = lzss_pkg::ST_CMD;
                    end
                end
            end
            default: n_state = lzss_pkg::ST_HDR0;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            lzss_pkg::ST_HDR0: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.hdr_ld   = i_stat.in_valid;
                o_cmd.hdr_idx  = lzss_pkg::HDR_B0;
            end
            lzss_pkg::ST_HDR1: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.hdr_ld   = i_stat.in_valid;
                o_cmd.hdr_idx  = lzss_pkg::HDR_B1;
            end
            lzss_pkg::ST_HDR2: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.hdr_ld   = i_stat.in_valid;
                o_cmd.hdr_idx  = lzss_pkg::HDR_B2;
            end
            lzss_pkg::ST_HDR3: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.hdr_ld   = i_stat.in_valid;
                o_cmd.hdr_idx  = lzss_pkg::HDR_B3;
            end
            lzss_pkg::ST_CMD: begin
                o_cmd.in_ready   = 1'b1;
                o_cmd.flag_ld    = i_stat.in_valid && i_stat.flag_empty;
                o_cmd.flag_shift = i_stat.in_valid && !i_stat.flag_empty && i_stat.flag_bit;
                o_cmd.lit_ld     = i_stat.in_valid && !i_stat.flag_empty && i_stat.flag_bit;
                o_cmd.off_ld     = i_stat.in_valid && !i_stat.flag_empty && !i_stat.flag_bit;
            end
            lzss_pkg::ST_OFFHI: begin
                o_cmd.in_ready   = 1'b1;
                o_cmd.copy_start = i_stat.in_valid;
                o_cmd.flag_shift = i_stat.in_valid;
            end
            lzss_pkg::ST_LIT: begin
                o_cmd.emit_lit = i_stat.out_free;
            end
            lzss_pkg::ST_COPY: begin
                o_cmd.emit_copy = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    `LZSS_ASSERT_NXT(a_copy_enters, i_clk, i_rst_n, o_cmd.copy_start, r_state == lzss_pkg::ST_COPY, "copy start did not enter the copy state")
    `LZSS_ASSERT_NXT(a_end_to_header, i_clk, i_rst_n, (o_cmd.emit_lit || o_cmd.emit_copy) && i_stat.emit_last, r_state == lzss_pkg::ST_HDR0, "stream end did not return to header parsing")
    `LZSS_ASSERT_IMP(a_emit_needs_slot, i_clk, i_rst_n, o_cmd.emit_lit || o_cmd.emit_copy, i_stat.out_free && !o_cmd.in_ready, "byte emitted without a free output slot")

endmodule

// File: rtl/core/lzss_dp.sv
// Datapath of the LZSS decompressor: length counter, flags, history window and output register.
`include "lzss_stream_decompressor_assert.svh"

module lzss_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lzss_pkg::t_cmd  i_cmd,
    output lzss_pkg::t_stat o_stat,
    input  logic            i_in_valid,
    input  logic [7:0]      i_in_byte,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_stream_end
);

    localparam int AW = lzss_pkg::ADDR_W;
    localparam int FW = lzss_pkg::FILL_W;

    logic [31:0]                 r_count;
    logic [8:0]                  r_flags;
    logic [7:0]                  r_held_low;
    logic [7:0]                  r_lit;
    logic [AW-1:0]               r_wp;
    logic [FW-1:0]               r_fill;
    logic [lzss_pkg::LEN_W-1:0]  r_copy_left;
    logic [AW-1:0]               r_rd_addr;
    logic [7:0]                  r_rd_raw;
    logic                        r_rd_ok;
    logic                        r_rd_byp;
    logic [7:0]                  r_byp_data;
    logic                        r_out_valid;
    logic [7:0]                  r_out_byte;
    logic                        r_run_last;
    logic                        r_stream_end;

    logic [7:0] window [lzss_pkg::WINDOW_SIZE];

    logic          emit;
    logic [7:0]    copy_val;
    logic [7:0]    emit_val;
    logic          emit_last;
    logic          copy_last;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_rel;
    logic          rd_byp;
    logic          rd_ok;

    assign emit      = i_cmd.emit_lit || i_cmd.emit_copy;
    assign emit_last = (r_count == 32'd1);
    assign copy_last = (r_copy_left == lzss_pkg::LEN_W'(1));

    // A byte read in the same cycle its address was written takes the written value;
    // an entry not yet written since stream start reads as the fill byte.
    assign copy_val = r_rd_byp ? r_byp_data : (r_rd_ok ? r_rd_raw : lzss_pkg::FILL_BYTE);
    assign emit_val = i_cmd.emit_lit ? r_lit : copy_val;

    assign rd_en   = i_cmd.copy_start || (i_cmd.emit_copy && !emit_last && !copy_last);
    assign rd_addr = i_cmd.copy_start ? {i_in_byte[7:4], r_held_low} : r_rd_addr + AW'(1);
    assign rd_byp  = i_cmd.emit_copy && (rd_addr == r_wp);
    // Entries written since stream start form a run beginning at the start pointer.
    assign rd_rel  = rd_addr - lzss_pkg::START_PTR;
    assign rd_ok   = ({1'b0, rd_rel} < r_fill);

    always_comb begin
        o_stat.in_valid   = i_in_valid;
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.hdr_zero   = ({i_in_byte, r_count[23:0]} == 32'd0);
        o_stat.flag_empty = (r_flags[8:1] == 8'd0);
        o_stat.flag_bit   = r_flags[0];
        o_stat.emit_last  = emit_last;
        o_stat.copy_last  = copy_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_flags     <= '0;
            r_wp        <= lzss_pkg::START_PTR;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.hdr_ld) begin
                case (i_cmd.hdr_idx)
                    lzss_pkg::HDR_B0: r_count <= {24'd0, i_in_byte};
                    lzss_pkg::HDR_B1: r_count[15:8] <= i_in_byte;
                    lzss_pkg::HDR_B2: r_count[23:16] <= i_in_byte;
                    lzss_pkg::HDR_B3: begin
                        r_count[31:24] <= i_in_byte;
                        r_wp           <= lzss_pkg::START_PTR;
                        r_fill         <= '0;
                        r_flags        <= '0;
                    end
                    default: r_count <= r_count;
                endcase
            end
            if (i_cmd.flag_ld) begin
                r_flags <= {1'b1, i_in_byte};
            end else if (i_cmd.flag_shift) begin
                r_flags <= r_flags >> 1;
            end
            if (emit) begin
                r_count <= r_count - 32'd1;
                r_wp    <= r_wp + AW'(1);
                if (r_fill != FW'(lzss_pkg::WINDOW_SIZE)) begin
                    r_fill <= r_fill + FW'(1);
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lit_ld) begin
            r_lit <= i_in_byte;
        end
        if (i_cmd.off_ld) begin
            r_held_low <= i_in_byte;
        end
        if (i_cmd.copy_start) begin
            r_copy_left <= lzss_pkg::LEN_W'({1'b0, i_in_byte[3:0]}) + lzss_pkg::MIN_MATCH;
        end else if (i_cmd.emit_copy) begin
            r_copy_left <= r_copy_left - lzss_pkg::LEN_W'(1);
        end
        if (rd_en) begin
            r_rd_addr  <= rd_addr;
            r_rd_ok    <= rd_ok;
            r_rd_byp   <= rd_byp;
            r_byp_data <= emit_val;
        end
        if (emit) begin
            r_out_byte   <= emit_val;
            r_run_last   <= i_cmd.emit_lit || copy_last || emit_last;
            r_stream_end <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            window[r_wp] <= emit_val;
        end
        if (rd_en) begin
            r_rd_raw <= window[rd_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_stream_end = r_stream_end;

    `LZSS_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(lzss_pkg::WINDOW_SIZE), "window fill count overran")
    `LZSS_ASSERT_NXT(a_emit_advances_wp, i_clk, i_rst_n, emit, r_wp == $past(r_wp) + AW'(1), "write pointer did not advance on emit")
    `LZSS_ASSERT_NXT(a_emit_shows_beat, i_clk, i_rst_n, emit, r_out_valid && (r_stream_end == $past(emit_last)), "emitted byte not presented correctly")

endmodule

// File: tb/lzss_decomp_scoreboard.sv
// Scoreboard that predicts the decompressed bytes and compares them with the output channel.
`timescale 1ns / 1ps

module lzss_decomp_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    lzss_in_if   i_in_ch,
    lzss_out_if  i_out_ch,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
    } t_out_beat;

    logic [7:0]                  window_mem [lzss_pkg::WINDOW_SIZE];
    logic [lzss_pkg::ADDR_W-1:0] wr_ptr;
    logic [8:0]                  flag_bits;
    logic [31:0]                 bytes_left;
    lzss_pkg::t_state            parse_st;
    logic [7:0]                  off_low;
    t_out_beat                   pending_q [$];
    t_out_beat                   got_beat;
    t_out_beat                   want_beat;
    int                          mismatches = 0;
    int                          checked = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    function automatic void clear_window();
        for (int i = 0; i < lzss_pkg::WINDOW_SIZE; i++) begin
            window_mem[i] = lzss_pkg::FILL_BYTE;
        end
        wr_ptr    = lzss_pkg::START_PTR;
        flag_bits = '0;
    endfunction

    function automatic void emit_byte(input logic [7:0] value, input logic beat_last);
        t_out_beat res;
        window_mem[wr_ptr] = value;
        wr_ptr             = wr_ptr + 1'b1;
        bytes_left         = bytes_left - 1;
        res.data       = value;
        res.run_last   = beat_last;
        res.stream_end = (bytes_left == 0);
        pending_q.insert(pending_q.size(), res);
        if (bytes_left == 0) begin
            parse_st = lzss_pkg::ST_HDR0;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        logic [lzss_pkg::ADDR_W-1:0] src;
        logic [lzss_pkg::LEN_W-1:0]  run;
        logic [31:0]                 n_emit;
        case (parse_st)
            lzss_pkg::ST_HDR1: begin
                bytes_left = bytes_left | {16'h0, b, 8'h0};
                parse_st   = lzss_pkg::ST_HDR2;
            end
            lzss_pkg::ST_HDR2: begin
                bytes_left = bytes_left | {8'h0, b, 16'h0};
                parse_st   = lzss_pkg::ST_HDR3;
            end
            lzss_pkg::ST_HDR3: begin
                bytes_left = bytes_left | {b, 24'h0};
                clear_window();
                parse_st = (bytes_left == 0) ? lzss_pkg::ST_HDR0 : lzss_pkg::ST_CMD;
            end
            lzss_pkg::ST_CMD: begin
                // A marker bit sits above the unused flags; at most one left means reload.
                if (flag_bits <= 9'd1) begin
                    flag_bits = {1'b1, b};
                end else if (flag_bits[0]) begin
                    flag_bits = flag_bits >> 1;
                    emit_byte(b, 1'b1);
                end else begin
                    off_low  = b;
                    parse_st = lzss_pkg::ST_OFFHI;
                end
            end
            lzss_pkg::ST_OFFHI: begin
                src       = {b[7:4], off_low};
                run       = lzss_pkg::LEN_W'(b[3:0]) + lzss_pkg::MIN_MATCH;
                flag_bits = flag_bits >> 1;
                parse_st  = lzss_pkg::ST_CMD;
                // The copy is cut short when the stream length runs out inside it.
                n_emit = (32'(run) < bytes_left) ? 32'(run) : bytes_left;
                for (int i = 0; i < n_emit; i++) begin
                    emit_byte(window_mem[src], 32'(i) == n_emit - 1);
                    src = src + 1'b1;
                end
            end
            default: begin
                bytes_left = {24'h0, b};
                parse_st   = lzss_pkg::ST_HDR1;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_window();
            bytes_left = '0;
            parse_st   = lzss_pkg::ST_HDR0;
            off_low    = '0;
            pending_q.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_byte(i_in_ch.packed_byte);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                got_beat.data       = i_out_ch.out_byte;
                got_beat.run_last   = i_out_ch.run_last;
                got_beat.stream_end = i_out_ch.stream_end;
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected beat byte %02h run_last %0b stream_end %0b",
                                 $realtime, got_beat.data, got_beat.run_last,
                                 got_beat.stream_end);
                    end
                end else begin
                    want_beat = pending_q.pop_front();
                    checked++;
                    if (got_beat !== want_beat) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: beat %0d expected byte %02h run_last %0b ",
                                      "stream_end %0b, got byte %02h run_last %0b stream_end %0b"},
                                     $realtime, checked, want_beat.data, want_beat.run_last,
                                     want_beat.stream_end, got_beat.data, got_beat.run_last,
                                     got_beat.stream_end);
                        end
                    end
                end
            end
        end
        o_outstanding <= pending_q.size();
        o_mismatches  <= mismatches;
        o_checked     <= checked;
    end

endmodule

// File: tb/testbench.sv
// Top of the decompressor testbench: clock, reset, compressed stream stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int TARGET_BYTES   = 180;
    localparam int HOLD_AFTER     = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    typedef enum logic [2:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY, RX_SQUARE} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic rx_ready = 1'b0;

    lzss_in_if  in_ch ();
    lzss_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    int mismatches;
    int outstanding;
    int checked;

    lzss_stream_decompressor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lzss_decomp_scoreboard u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (in_ch),
        .i_out_ch      (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #5 i_clk = ~i_clk;

    // Output side: a randomly chosen stall mode, plus one long hold-off.
    t_rx_mode rx_mode;
    int       rx_cycle;
    int       in_beats;
    int       hold_left;
    logic     hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready  <= 1'b0;
            rx_cycle  <= 0;
            in_beats  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
            rx_mode   <= RX_OPEN;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (in_ch.valid && in_ch.ready) begin
                in_beats <= in_beats + 1;
            end
            if (rx_cycle % 100 == 99) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 4));
            end
            if (hold_left != 0) begin
                rx_ready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && in_beats >= HOLD_AFTER) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                rx_ready  <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   rx_ready <= 1'b1;
                    RX_COIN:   rx_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rx_ready <= (rx_cycle % 4 == 0);
                    RX_MOSTLY: rx_ready <= ($urandom_range(0, 9) != 0);
                    default:   rx_ready <= rx_cycle[2];
                endcase
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat moved on either channel for %0d cycles",
                         WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    int burst_left = 0;
    int bytes_sent = 0;
    int streams = 0;
    int empty_streams = 0;
    int copies = 0;

    task automatic push_byte(input logic [7:0] value);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.packed_byte <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Builds a well-formed stream whose commands produce at least the declared length.
    task automatic send_stream(input int unsigned total);
        int unsigned made;
        int unsigned run;
        logic [7:0]  flags;
        logic [3:0]  len_code;
        logic [11:0] off;
        logic [11:0] gen_ptr;
        push_byte(total[7:0]);
        push_byte(total[15:8]);
        push_byte(total[23:16]);
        push_byte(total[31:24]);
        streams++;
        if (total == 0) begin
            empty_streams++;
        end
        gen_ptr = lzss_pkg::START_PTR;
        made    = 0;
        while (made < total) begin
            flags = 8'($urandom);
            push_byte(flags);
            for (int k = 0; k < 8 && made < total; k++) begin
                if (flags[k]) begin
                    push_byte(8'($urandom));
                    made++;
                    gen_ptr = gen_ptr + 1'b1;
                end else begin
                    len_code = 4'($urandom_range(0, 15));
                    // Half the copies reach back into recent output, often overlapping it.
                    if ($urandom_range(0, 1) == 1) begin
                        off = gen_ptr - 12'($urandom_range(1, 18));
                    end else begin
                        off = 12'($urandom);
                    end
                    push_byte(off[7:0]);
                    push_byte({off[11:8], len_code});
                    run = len_code + 3;
                    if (run > total - made) begin
                        run = total - made;
                    end
                    made    += run;
                    gen_ptr = gen_ptr + 12'(run);
                    copies++;
                end
            end
        end
    endtask

    initial begin
        int unsigned pick;
        int unsigned total;
        logic [7:0]  opening [$];
        // Empty stream; literal then a long copy cut by the length; copy from a freshly
        // cleared window; copy whose source wraps past the window end.
        opening = '{8'h00, 8'h00, 8'h00, 8'h00,
                    8'h05, 8'h00, 8'h00, 8'h00, 8'hFD, 8'hFF, 8'hEE, 8'hFF,
                    8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'hF0,
                    8'h05, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF, 8'hFF};
        in_ch.valid       = 1'b0;
        in_ch.packed_byte = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[i]) begin
            push_byte(opening[i]);
        end
        streams       += 4;
        empty_streams += 1;
        copies        += 3;

        while (bytes_sent < TARGET_BYTES) begin
            pick = $urandom_range(0, 14);
            if (pick == 0) begin
                total = 0;
            end else if (pick == 1) begin
                total = $urandom_range(256, 400);
            end else begin
                total = $urandom_range(1, 40);
            end
            send_stream(total);
            if (streams == 10) begin
                wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d streams (%0d empty), %0d compressed bytes, %0d back-references.",
                 streams, empty_streams, bytes_sent, copies);
        $display("%0d decompressed bytes compared; output held off %0d cycles once.",
                 checked, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
